// ===== hdl/lsts_pkg.sv =====
// Package for the least-squares trend slope unit: item structs, sequencer
// states and width helpers. No dependencies.
`default_nettype none

package lsts_pkg;

  localparam int SAMPLE_W        = 24;
  localparam int SLOPE_W         = 48;
  localparam int COUNT_W         = 11;
  localparam int MAX_SAMPLES_DEF = 1024;
  localparam int FRAC_BITS_DEF   = 16;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } lsts_in_t;

  typedef struct packed {
    logic signed [SLOPE_W-1:0] slope;
    logic [COUNT_W-1:0]        sample_count;
    logic                      overflow;
  } lsts_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETTLE,
    ST_MUL_NXY,
    ST_MUL_XY,
    ST_SUB_NUM,
    ST_MUL_NXX,
    ST_MUL_XX,
    ST_SUB_DEN,
    ST_ABS,
    ST_DIV,
    ST_FIN
  } lsts_state_t;

  function automatic int lsts_max(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  // x runs 0 .. max-1
  function automatic int x_w(input int max_samples);
    return $clog2(max_samples);
  endfunction

  function automatic int cnt_w(input int max_samples);
    return $clog2(max_samples + 1);
  endfunction

  function automatic int sum_pos_w(input int max_samples);
    return 2 * x_w(max_samples);
  endfunction

  function automatic int sum_sq_w(input int max_samples);
    return 3 * x_w(max_samples);
  endfunction

  function automatic int sum_val_w(input int max_samples);
    return SAMPLE_W + x_w(max_samples);
  endfunction

  function automatic int sum_xy_w(input int max_samples);
    return SAMPLE_W + 2 * x_w(max_samples);
  endfunction

  // datapath width of the shared adder: holds numerator, denominator, negation
  function automatic int alu_w(input int max_samples);
    return lsts_max(26 + 3 * x_w(max_samples), SLOPE_W + 1);
  endfunction

endpackage

`default_nettype wire

// ===== hdl/lsts_alu.sv =====
// Shared add/subtract unit of the slope engine.
// Depends on nothing; carry out doubles as unsigned a >= b on subtract.
`default_nettype none

module lsts_alu #(
  parameter int W = 64
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic         sub,
  output logic [W-1:0] sum,
  output logic         cout
);

  logic [W:0] full;

  always_comb begin
    full = {1'b0, a} + {1'b0, (sub ? ~b : b)} + (W+1)'(sub);
  end

  assign sum  = full[W-1:0];
  assign cout = full[W];

endmodule

`default_nettype wire

// ===== hdl/lsts_accum.sv =====
// Running sums of x, x*x, y and x*y for the current run.
// Depends on lsts_pkg. One product stage, then the accumulate stage.
`default_nettype none

module lsts_accum import lsts_pkg::*; #(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     take,
  input  lsts_in_t                                 in_item,
  input  logic                                     clear,
  output logic [cnt_w(MAX_SAMPLES)-1:0]            count,
  output logic                                     too_many,
  output logic [sum_pos_w(MAX_SAMPLES)-1:0]        sum_pos,
  output logic [sum_sq_w(MAX_SAMPLES)-1:0]         sum_sq,
  output logic signed [sum_val_w(MAX_SAMPLES)-1:0] sum_val,
  output logic signed [sum_xy_w(MAX_SAMPLES)-1:0]  sum_xy
);

  localparam int XW   = x_w(MAX_SAMPLES);
  localparam int CW   = cnt_w(MAX_SAMPLES);
  localparam int SPW  = sum_pos_w(MAX_SAMPLES);
  localparam int SQW  = sum_sq_w(MAX_SAMPLES);
  localparam int SVW  = sum_val_w(MAX_SAMPLES);
  localparam int SXYW = sum_xy_w(MAX_SAMPLES);
  localparam int PXYW = SAMPLE_W + XW;

  logic [CW-1:0]              count_r, count_nxt;
  logic                       too_many_r, too_many_nxt;
  logic [SPW-1:0]             sum_pos_r, sum_pos_nxt;
  logic [SQW-1:0]             sum_sq_r, sum_sq_nxt;
  logic signed [SVW-1:0]      sum_val_r, sum_val_nxt;
  logic signed [SXYW-1:0]     sum_xy_r, sum_xy_nxt;
  logic                       upd_r, upd_nxt;

  // product stage (payload, no reset)
  logic [XW-1:0]              x_r, x_nxt;
  logic signed [SAMPLE_W-1:0] y_r, y_nxt;
  logic signed [PXYW-1:0]     pxy_r, pxy_nxt;
  logic [2*XW-1:0]            pxx_r, pxx_nxt;

  logic                       room;
  logic [XW-1:0]              x_cur;
  logic signed [XW:0]         xs;
  logic signed [PXYW:0]       pxy_full;

  assign room     = count_r < CW'(MAX_SAMPLES);
  assign x_cur    = count_r[XW-1:0];
  assign xs       = $signed({1'b0, x_cur});
  assign pxy_full = (PXYW+1)'(xs) * (PXYW+1)'($signed(in_item.sample));

  always_comb begin
    x_nxt        = x_r;
    y_nxt        = y_r;
    pxy_nxt      = pxy_r;
    pxx_nxt      = pxx_r;
    count_nxt    = count_r;
    too_many_nxt = too_many_r;
    upd_nxt      = take && room;
    sum_pos_nxt  = sum_pos_r;
    sum_sq_nxt   = sum_sq_r;
    sum_val_nxt  = sum_val_r;
    sum_xy_nxt   = sum_xy_r;

    if (take) begin
      if (room) begin
        x_nxt     = x_cur;
        y_nxt     = in_item.sample;
        pxy_nxt   = pxy_full[PXYW-1:0];
        pxx_nxt   = (2*XW)'(x_cur) * (2*XW)'(x_cur);
        count_nxt = count_r + CW'(1);
      end else begin
        too_many_nxt = 1'b1;
      end
    end

    if (upd_r) begin
      sum_pos_nxt = sum_pos_r + SPW'(x_r);
      sum_sq_nxt  = sum_sq_r + SQW'(pxx_r);
      sum_val_nxt = sum_val_r + SVW'(y_r);
      sum_xy_nxt  = sum_xy_r + SXYW'(pxy_r);
    end

    if (clear) begin
      count_nxt    = '0;
      too_many_nxt = 1'b0;
      upd_nxt      = 1'b0;
      sum_pos_nxt  = '0;
      sum_sq_nxt   = '0;
      sum_val_nxt  = '0;
      sum_xy_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      too_many_r <= 1'b0;
      upd_r      <= 1'b0;
      sum_pos_r  <= '0;
      sum_sq_r   <= '0;
      sum_val_r  <= '0;
      sum_xy_r   <= '0;
    end else begin
      count_r    <= count_nxt;
      too_many_r <= too_many_nxt;
      upd_r      <= upd_nxt;
      sum_pos_r  <= sum_pos_nxt;
      sum_sq_r   <= sum_sq_nxt;
      sum_val_r  <= sum_val_nxt;
      sum_xy_r   <= sum_xy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    pxy_r <= pxy_nxt;
    pxx_r <= pxx_nxt;
  end

  assign count    = count_r;
  assign too_many = too_many_r;
  assign sum_pos  = sum_pos_r;
  assign sum_sq   = sum_sq_r;
  assign sum_val  = sum_val_r;
  assign sum_xy   = sum_xy_r;

endmodule

`default_nettype wire

// ===== hdl/lsts_engine.sv =====
// End-of-run slope engine: shift-add products, subtracts, restoring divide,
// all through one shared lsts_alu. Depends on lsts_pkg and lsts_alu.
`default_nettype none

module lsts_engine import lsts_pkg::*; #(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     go,
  input  logic [cnt_w(MAX_SAMPLES)-1:0]            count,
  input  logic                                     too_many,
  input  logic [sum_pos_w(MAX_SAMPLES)-1:0]        sum_pos,
  input  logic [sum_sq_w(MAX_SAMPLES)-1:0]         sum_sq,
  input  logic signed [sum_val_w(MAX_SAMPLES)-1:0] sum_val,
  input  logic signed [sum_xy_w(MAX_SAMPLES)-1:0]  sum_xy,
  output logic                                     busy,
  output logic                                     clear,
  output logic                                     out_strobe,
  output lsts_out_t                                out_item
);

  localparam int AW  = alu_w(MAX_SAMPLES);
  localparam int MW  = sum_pos_w(MAX_SAMPLES);   // multiplier operand bits
  localparam int MBW = $clog2(MW);
  localparam int DVW = AW + FRAC_BITS;           // dividend bits
  localparam int STW = $clog2(DVW);

  lsts_state_t state_r, state_nxt;

  logic [STW-1:0]     cnt_r, cnt_nxt;
  logic [AW-1:0]      acc_r, acc_nxt;
  logic [AW-1:0]      num_r, num_nxt;
  logic [AW-1:0]      den_r, den_nxt;
  logic [AW-1:0]      rem_r, rem_nxt;
  logic [DVW-1:0]     dvd_r, dvd_nxt;
  logic [SLOPE_W-1:0] q_r, q_nxt;
  logic               qhi_r, qhi_nxt;
  logic               neg_r, neg_nxt;
  logic               zero_r, zero_nxt;
  lsts_out_t          out_r, out_nxt;
  logic               strobe_r, strobe_nxt;

  logic [AW-1:0]      alu_a, alu_b, alu_sum, mag;
  logic               alu_sub, alu_co;
  logic [MW-1:0]      mplier;
  logic [AW-1:0]      mcand;
  logic               mul_bit, first, cnt_zero, is_mul, den_zero;
  logic [SLOPE_W-1:0] lim, q_sat;

  lsts_alu #(.W(AW)) u_alu (
    .a    (alu_a),
    .b    (alu_b),
    .sub  (alu_sub),
    .sum  (alu_sum),
    .cout (alu_co)
  );

  assign cnt_zero = cnt_r == '0;
  assign first    = cnt_r == STW'(MW - 1);
  assign den_zero = (den_r == '0) || den_r[AW-1];
  assign is_mul   = state_r inside {ST_MUL_NXY, ST_MUL_XY, ST_MUL_NXX, ST_MUL_XX};

  // operand pick for the product steps
  always_comb begin
    case (state_r)
      ST_MUL_NXY: begin
        mplier = MW'(count);
        mcand  = AW'(sum_xy);
      end
      ST_MUL_XY: begin
        mplier = MW'(sum_pos);
        mcand  = AW'(sum_val);
      end
      ST_MUL_NXX: begin
        mplier = MW'(count);
        mcand  = AW'(sum_sq);
      end
      ST_MUL_XX: begin
        mplier = MW'(sum_pos);
        mcand  = AW'(sum_pos);
      end
      default: begin
        mplier = '0;
        mcand  = '0;
      end
    endcase
  end

  assign mul_bit = mplier[cnt_r[MBW-1:0]];

  // saturate quotient at the 48-bit signed limit for its sign
  always_comb begin
    lim   = neg_r ? {1'b1, {(SLOPE_W-1){1'b0}}} : {1'b0, {(SLOPE_W-1){1'b1}}};
    q_sat = (qhi_r || (q_r > lim)) ? lim : q_r;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:    if (go) state_nxt = ST_SETTLE;
      ST_SETTLE:  state_nxt = ST_MUL_NXY;
      ST_MUL_NXY: if (cnt_zero) state_nxt = ST_MUL_XY;
      ST_MUL_XY:  if (cnt_zero) state_nxt = ST_SUB_NUM;
      ST_SUB_NUM: state_nxt = ST_MUL_NXX;
      ST_MUL_NXX: if (cnt_zero) state_nxt = ST_MUL_XX;
      ST_MUL_XX:  if (cnt_zero) state_nxt = ST_SUB_DEN;
      ST_SUB_DEN: state_nxt = ST_ABS;
      ST_ABS:     state_nxt = den_zero ? ST_FIN : ST_DIV;
      ST_DIV:     if (cnt_zero) state_nxt = ST_FIN;
      ST_FIN:     state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // outputs: shared adder operands and handshake controls
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state_r)
      ST_MUL_NXY, ST_MUL_XY, ST_MUL_NXX, ST_MUL_XX: begin
        alu_a = first ? '0 : {acc_r[AW-2:0], 1'b0};
        alu_b = mul_bit ? mcand : '0;
      end
      ST_SUB_NUM: begin
        alu_a   = num_r;
        alu_b   = acc_r;
        alu_sub = 1'b1;
      end
      ST_SUB_DEN: begin
        alu_a   = den_r;
        alu_b   = acc_r;
        alu_sub = 1'b1;
      end
      ST_ABS: begin
        alu_b   = num_r;
        alu_sub = 1'b1;
      end
      ST_DIV: begin
        alu_a   = {rem_r[AW-2:0], dvd_r[DVW-1]};
        alu_b   = den_r;
        alu_sub = 1'b1;
      end
      ST_FIN: begin
        alu_b   = AW'(q_sat);
        alu_sub = 1'b1;
      end
      default: begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
      end
    endcase
    busy  = state_r != ST_IDLE;
    clear = state_r == ST_FIN;
  end

  // datapath
  always_comb begin
    cnt_nxt    = (state_nxt != state_r)
               ? ((state_nxt == ST_DIV) ? STW'(DVW - 1) : STW'(MW - 1))
               : cnt_r - STW'(1);
    acc_nxt    = is_mul ? alu_sum : acc_r;
    num_nxt    = num_r;
    den_nxt    = den_r;
    rem_nxt    = rem_r;
    dvd_nxt    = dvd_r;
    q_nxt      = q_r;
    qhi_nxt    = qhi_r;
    neg_nxt    = neg_r;
    zero_nxt   = zero_r;
    out_nxt    = out_r;
    strobe_nxt = 1'b0;
    mag        = num_r[AW-1] ? alu_sum : num_r;

    case (state_r)
      ST_MUL_NXY: if (cnt_zero) num_nxt = alu_sum;
      ST_SUB_NUM: num_nxt = alu_sum;
      ST_MUL_NXX: if (cnt_zero) den_nxt = alu_sum;
      ST_SUB_DEN: den_nxt = alu_sum;
      ST_ABS: begin
        neg_nxt  = num_r[AW-1];
        zero_nxt = den_zero;
        dvd_nxt  = DVW'(mag) << FRAC_BITS;
        rem_nxt  = '0;
        q_nxt    = '0;
        qhi_nxt  = 1'b0;
      end
      ST_DIV: begin
        rem_nxt = alu_co ? alu_sum : alu_a;
        dvd_nxt = {dvd_r[DVW-2:0], 1'b0};
        q_nxt   = {q_r[SLOPE_W-2:0], alu_co};
        qhi_nxt = qhi_r | q_r[SLOPE_W-1];
      end
      ST_FIN: begin
        out_nxt.slope        = zero_r ? '0 : (neg_r ? alu_sum[SLOPE_W-1:0] : q_sat);
        out_nxt.sample_count = COUNT_W'(count);
        out_nxt.overflow     = too_many;
        strobe_nxt           = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    acc_r  <= acc_nxt;
    num_r  <= num_nxt;
    den_r  <= den_nxt;
    rem_r  <= rem_nxt;
    dvd_r  <= dvd_nxt;
    q_r    <= q_nxt;
    qhi_r  <= qhi_nxt;
    neg_r  <= neg_nxt;
    zero_r <= zero_nxt;
    out_r  <= out_nxt;
  end

  assign out_strobe = strobe_r;
  assign out_item   = out_r;

endmodule

`default_nettype wire

// ===== hdl/least_squares_trend_slope_unit.sv =====
// Top level of the least-squares trend slope unit: sample accumulator plus
// the end-of-run slope engine. Depends on lsts_pkg, lsts_accum, lsts_engine.
//
// Usage
//  - Input: drive in_item (sample, last) with start; the item is taken on a
//    rising edge where start is high and busy is low.
//  - Ordinary samples leave busy low, so a new sample can be offered every
//    cycle. x*y and x*x are formed in a product stage
//    and summed in the next cycle.
//  - A sample with last set ends the run. busy rises the next cycle and
//    stays high while the engine runs its sequence on one shared adder:
//    four shift-add products of MW = 2*clog2(MAX_SAMPLES) steps each, two
//    subtracts, a sign step and a restoring divide of AW + FRAC_BITS steps.
//    The divide is skipped when the denominator is zero (fewer than two
//    samples).
//  - Result: out_item is valid for exactly one cycle with out_strobe high;
//    that cycle is the first one with busy low again. The receiver cannot
//    stall; the item must be taken in that cycle.
//  - Samples past MAX_SAMPLES are dropped and flag overflow on the result.
//  - Reset (rst_n low, synchronous) clears all sums, the count, the flag
//    and the sequencer; the unit is ready on the first cycle after reset.
`default_nettype none

module least_squares_trend_slope_unit import lsts_pkg::*; #(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  lsts_in_t  in_item,
  output logic      out_strobe,
  output lsts_out_t out_item
);

  localparam int CW   = cnt_w(MAX_SAMPLES);
  localparam int SPW  = sum_pos_w(MAX_SAMPLES);
  localparam int SQW  = sum_sq_w(MAX_SAMPLES);
  localparam int SVW  = sum_val_w(MAX_SAMPLES);
  localparam int SXYW = sum_xy_w(MAX_SAMPLES);

  logic                   take, go, clear;
  logic [CW-1:0]          count;
  logic                   too_many;
  logic [SPW-1:0]         sum_pos;
  logic [SQW-1:0]         sum_sq;
  logic signed [SVW-1:0]  sum_val;
  logic signed [SXYW-1:0] sum_xy;

  // item handshake; a last item also kicks off the engine
  assign take = start && !busy;
  assign go   = take && in_item.last;

  lsts_accum #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_accum (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (take),
    .in_item  (in_item),
    .clear    (clear),
    .count    (count),
    .too_many (too_many),
    .sum_pos  (sum_pos),
    .sum_sq   (sum_sq),
    .sum_val  (sum_val),
    .sum_xy   (sum_xy)
  );

  // engine waits in its settle state for the last sample's sums to land
  lsts_engine #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .FRAC_BITS   (FRAC_BITS)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .go         (go),
    .count      (count),
    .too_many   (too_many),
    .sum_pos    (sum_pos),
    .sum_sq     (sum_sq),
    .sum_val    (sum_val),
    .sum_xy     (sum_xy),
    .busy       (busy),
    .clear      (clear),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule

`default_nettype wire

// ===== hdl/lsts_checker.sv =====
// Port-level checks for the trend slope unit, bound to the top level.
// Depends on lsts_pkg.
`default_nettype none

module lsts_checker import lsts_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input lsts_in_t  in_item,
  input logic      out_strobe,
  input lsts_out_t out_item
);

  logic taken;
  assign taken = start && !busy;

  // a last item always starts the slope computation
  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (taken && in_item.last) |=> busy)
    else $error("last item did not raise busy");

  // a mid-run item never stalls the input
  a_mid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (taken && !in_item.last) |=> !busy)
    else $error("mid-run item raised busy");

  // finishing a computation always delivers a result
  a_end_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(busy) && $past(rst_n)) |-> out_strobe)
    else $error("busy dropped without a result");

  // one result per run, and only while idle
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (!busy && !$past(out_strobe)))
    else $error("result strobe repeated or shown while busy");

  // a strobed result carries only known bits
  a_result_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !$isunknown(out_item))
    else $error("result shown with unknown bits");

endmodule

bind least_squares_trend_slope_unit lsts_checker u_lsts_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_item    (in_item),
  .out_strobe (out_strobe),
  .out_item   (out_item)
);

`default_nettype wire
